// File: rtl/bounded_sorted_array_list_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the bounded sorted array list
// Checks compile in simulation only; the synthesis build sees empty bodies.
// ----------------------------------------------------------------------------
`ifndef BOUNDED_SORTED_ARRAY_LIST_MACROS_SVH
`define BOUNDED_SORTED_ARRAY_LIST_MACROS_SVH
`ifndef SYNTHESIS
// property must hold at every rising clock edge outside reset
`define BSAL_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("bsal: property violated");
// condition must never be true outside reset
`define BSAL_ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("bsal: forbidden condition seen");
`else
`define BSAL_ASSERT(label, clk, rst_n, prop)
`define BSAL_ASSERT_NEVER(label, clk, rst_n, cond)
`endif
`endif

// File: rtl/bsal_pkg.sv
// ----------------------------------------------------------------------------
// bsal_pkg
// Shared types and constants of the bounded sorted array list.
// ----------------------------------------------------------------------------
package bsal_pkg;

    // default list capacity
    localparam int DEF_CAPACITY = 64;

    // field widths
    localparam int ACT_W   = 3;
    localparam int VALUE_W = 8;
    localparam int POS_W   = 6;
    localparam int LEN_W   = 7;

    // stream widths, whole bytes
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 24;

    // cells examined per scan cycle
    localparam int SCAN_LANES = 8;
    localparam int LANE_W     = $clog2(SCAN_LANES);

    // action codes; 6 and 7 are no-ops
    typedef enum logic [ACT_W-1:0] {
        ACT_APPEND = 3'd0,
        ACT_INSERT = 3'd1,
        ACT_REMOVE = 3'd2,
        ACT_SEARCH = 3'd3,
        ACT_READ   = 3'd4,
        ACT_CLEAR  = 3'd5
    } t_action;

    // per-cell command
    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_LOAD,
        CELL_SHIFT,
        CELL_PUT,
        CELL_INS,
        CELL_DEL
    } t_cell_op;

    // match condition evaluated on load
    typedef enum logic [1:0] {
        CMP_NONE,
        CMP_GE,
        CMP_EQ,
        CMP_IDX
    } t_cmp_kind;

    // command broadcast to every cell
    typedef struct packed {
        t_cell_op                op;
        t_cmp_kind               kind;
        logic [VALUE_W-1:0]      value;
    } t_cell_ctl;

    // one slot of the scan line
    typedef struct packed {
        logic                    hit;
        logic [VALUE_W-1:0]      val;
    } t_scan;

endpackage

// File: rtl/bsal_cell.sv
// ----------------------------------------------------------------------------
// bsal_cell
// One list entry: the stored value, a shift with both neighbors for insert
// and remove, and a scan slot that carries a match flag down the chain.
// ----------------------------------------------------------------------------
module bsal_cell #(
    parameter int IDX_W = $clog2(bsal_pkg::DEF_CAPACITY),
    parameter int CNT_W = $clog2(bsal_pkg::DEF_CAPACITY + 1)
) (
    input  logic                            i_clk,
    input  bsal_pkg::t_cell_ctl             i_ctl,
    input  logic [IDX_W-1:0]                i_index,
    input  logic [IDX_W-1:0]                i_pos,
    input  logic [CNT_W-1:0]                i_count,
    input  logic [bsal_pkg::VALUE_W-1:0]    i_left_val,
    input  logic [bsal_pkg::VALUE_W-1:0]    i_right_val,
    input  bsal_pkg::t_scan                 i_scan_in,
    output logic [bsal_pkg::VALUE_W-1:0]    o_val,
    output bsal_pkg::t_scan                 o_scan
);

    logic [bsal_pkg::VALUE_W-1:0] r_val;
    logic [bsal_pkg::VALUE_W-1:0] n_val;
    bsal_pkg::t_scan              r_scan;
    bsal_pkg::t_scan              n_scan;
    logic                         w_occ;
    logic                         w_match;

    // entry lies inside the list
    assign w_occ = CNT_W'(i_index) < i_count;

    // match condition for the current action
    always_comb begin
        case (i_ctl.kind)
            bsal_pkg::CMP_GE:  w_match = !($signed(r_val) < $signed(i_ctl.value));
            bsal_pkg::CMP_EQ:  w_match = (r_val == i_ctl.value);
            bsal_pkg::CMP_IDX: w_match = (i_index == i_pos);
            default:           w_match = 1'b0;
        endcase
    end

    // next value and scan slot
    always_comb begin
        n_val  = r_val;
        n_scan = r_scan;
        case (i_ctl.op)
            bsal_pkg::CELL_LOAD: begin
                n_scan.hit = w_occ && w_match;
                n_scan.val = r_val;
            end
            bsal_pkg::CELL_SHIFT: begin
                n_scan = i_scan_in;
            end
            bsal_pkg::CELL_PUT: begin
                if (i_index == i_pos) begin
                    n_val = i_ctl.value;
                end
            end
            bsal_pkg::CELL_INS: begin
                if (i_index > i_pos) begin
                    n_val = i_left_val;
                end else if (i_index == i_pos) begin
                    n_val = i_ctl.value;
                end
            end
            bsal_pkg::CELL_DEL: begin
                if (i_index >= i_pos) begin
                    n_val = i_right_val;
                end
            end
            default: begin
            end
        endcase
    end

    // payload only, no reset
    always_ff @(posedge i_clk) begin
        r_val  <= n_val;
        r_scan <= n_scan;
    end

    assign o_val  = r_val;
    assign o_scan = r_scan;

endmodule

// File: rtl/bsal_scan.sv
// ----------------------------------------------------------------------------
// bsal_scan
// Priority pick over the bottom scan lanes: first lane with a hit and its
// carried value.
// ----------------------------------------------------------------------------
module bsal_scan (
    input  bsal_pkg::t_scan                 i_lanes [bsal_pkg::SCAN_LANES],
    output logic                            o_hit,
    output logic [bsal_pkg::LANE_W-1:0]     o_lane,
    output logic [bsal_pkg::VALUE_W-1:0]    o_val
);

    // lowest lane wins
    always_comb begin
        o_hit  = 1'b0;
        o_lane = '0;
        o_val  = '0;
        for (int k = bsal_pkg::SCAN_LANES - 1; k >= 0; k--) begin
            if (i_lanes[k].hit) begin
                o_hit  = 1'b1;
                o_lane = bsal_pkg::LANE_W'(k);
                o_val  = i_lanes[k].val;
            end
        end
    end

endmodule

// File: rtl/bounded_sorted_array_list.sv
// Append, clear and unused codes go from the beat to the apply state, then to output.
// Insert, remove, search, read load the scan line first; it moves 8 cells per cycle to
// group m of the first match (at most ceil(CAPACITY/8) - 1), then apply and output.
// Throughput: one item at a time; the next beat is taken once the result is loaded
// into the output register, even while that result waits for i_m_tready.
// Reset (i_rst_n low, synchronous): list empty, no result pending; no clearing pass.
// ----------------------------------------------------------------------------
// bounded_sorted_array_list
// Fixed-capacity list of signed bytes built as a row of cells: append, sorted
// insert, remove, search, read and clear, one result beat per input beat.
// ----------------------------------------------------------------------------
`include "bounded_sorted_array_list_macros.svh"

module bounded_sorted_array_list #(
    parameter int CAPACITY = bsal_pkg::DEF_CAPACITY
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // action[2:0], value[10:3], position[16:11], zero pad
    input  logic [bsal_pkg::IN_TDATA_W-1:0]     i_s_tdata,
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    // ok[0], found_position[6:1], item[14:7], length[21:15], zero pad
    output logic [bsal_pkg::OUT_TDATA_W-1:0]    o_m_tdata,
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready
);

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int NG    = (CAPACITY + bsal_pkg::SCAN_LANES - 1) / bsal_pkg::SCAN_LANES;
    localparam int GRP_W = (NG > 1) ? $clog2(NG) : 1;
    localparam int PAD_W = bsal_pkg::OUT_TDATA_W - 1 - bsal_pkg::POS_W
                           - bsal_pkg::VALUE_W - bsal_pkg::LEN_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_APPLY,
        S_OUT
    } t_state;

    // control registers
    t_state                         r_state,  n_state;
    logic [CNT_W-1:0]               r_count,  n_count;
    logic [GRP_W-1:0]               r_grp,    n_grp;
    logic                           r_ovalid, n_ovalid;
    // payload registers
    bsal_pkg::t_action              r_act,    n_act;
    logic [bsal_pkg::VALUE_W-1:0]   r_value,  n_value;
    logic                           r_found,  n_found;
    logic [IDX_W-1:0]               r_fpos,   n_fpos;
    logic [bsal_pkg::VALUE_W-1:0]   r_fval,   n_fval;
    logic                           r_res_ok, n_res_ok;
    logic [IDX_W-1:0]               r_res_pos, n_res_pos;
    logic [bsal_pkg::VALUE_W-1:0]   r_res_item, n_res_item;
    logic [CNT_W-1:0]               r_res_len, n_res_len;
    logic                           r_out_ok, n_out_ok;
    logic [bsal_pkg::POS_W-1:0]     r_out_pos, n_out_pos;
    logic [bsal_pkg::VALUE_W-1:0]   r_out_item, n_out_item;
    logic [bsal_pkg::LEN_W-1:0]     r_out_len, n_out_len;

    // input fields
    bsal_pkg::t_action              w_in_act;
    logic [bsal_pkg::VALUE_W-1:0]   w_in_value;
    logic [bsal_pkg::POS_W-1:0]     w_in_pos;
    logic                           w_in_cap;
    logic                           w_accept;

    // cell row
    bsal_pkg::t_cell_ctl            w_ctl;
    logic [IDX_W-1:0]               w_cell_pos;
    logic [bsal_pkg::VALUE_W-1:0]   w_val  [CAPACITY];
    bsal_pkg::t_scan                w_scan [CAPACITY];
    bsal_pkg::t_scan                w_lane [bsal_pkg::SCAN_LANES];
    logic                           w_hit;
    logic [bsal_pkg::LANE_W-1:0]    w_hit_lane;
    logic [bsal_pkg::VALUE_W-1:0]   w_hit_val;
    logic                           w_has_room;

    assign w_in_act   = bsal_pkg::t_action'(i_s_tdata[2:0]);
    assign w_in_value = i_s_tdata[10:3];
    assign w_in_pos   = i_s_tdata[16:11];
    assign w_in_cap   = 32'(w_in_pos) < 32'(CAPACITY);
    assign o_s_tready = (r_state == S_IDLE);
    assign w_accept   = i_s_tvalid && o_s_tready;
    assign w_has_room = r_count < CNT_W'(CAPACITY);

    // row of cells; while scanning, the scan line steps SCAN_LANES cells per cycle
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [bsal_pkg::VALUE_W-1:0] w_left;
        logic [bsal_pkg::VALUE_W-1:0] w_right;
        bsal_pkg::t_scan              w_sin;

        if (g == 0) begin : g_first
            assign w_left = '0;
        end else begin : g_mid_l
            assign w_left = w_val[g-1];
        end

        if (g == CAPACITY - 1) begin : g_last
            assign w_right = w_val[g];
        end else begin : g_mid_r
            assign w_right = w_val[g+1];
        end

        if (g + bsal_pkg::SCAN_LANES < CAPACITY) begin : g_sin
            assign w_sin = w_scan[g + bsal_pkg::SCAN_LANES];
        end else begin : g_sin_end
            assign w_sin = '0;
        end

        bsal_cell #(
            .IDX_W (IDX_W),
            .CNT_W (CNT_W)
        ) u_cell (
            .i_clk       (i_clk),
            .i_ctl       (w_ctl),
            .i_index     (IDX_W'(g)),
            .i_pos       (w_cell_pos),
            .i_count     (r_count),
            .i_left_val  (w_left),
            .i_right_val (w_right),
            .i_scan_in   (w_sin),
            .o_val       (w_val[g]),
            .o_scan      (w_scan[g])
        );
    end

    // bottom lanes of the scan line
    for (genvar k = 0; k < bsal_pkg::SCAN_LANES; k++) begin : g_lane
        if (k < CAPACITY) begin : g_used
            assign w_lane[k] = w_scan[k];
        end else begin : g_pad
            assign w_lane[k] = '0;
        end
    end

    bsal_scan u_scan (
        .i_lanes (w_lane),
        .o_hit   (w_hit),
        .o_lane  (w_hit_lane),
        .o_val   (w_hit_val)
    );

    // sequencer: cell commands, scan, update and result
    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_grp      = r_grp;
        n_ovalid   = r_ovalid;
        n_act      = r_act;
        n_value    = r_value;
        n_found    = r_found;
        n_fpos     = r_fpos;
        n_fval     = r_fval;
        n_res_ok   = r_res_ok;
        n_res_pos  = r_res_pos;
        n_res_item = r_res_item;
        n_res_len  = r_res_len;
        n_out_ok   = r_out_ok;
        n_out_pos  = r_out_pos;
        n_out_item = r_out_item;
        n_out_len  = r_out_len;
        w_ctl.op    = bsal_pkg::CELL_HOLD;
        w_ctl.kind  = bsal_pkg::CMP_NONE;
        w_ctl.value = r_value;
        w_cell_pos  = '0;

        // output beat taken
        if (r_ovalid && i_m_tready) begin
            n_ovalid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_act   = w_in_act;
                    n_value = w_in_value;
                    n_grp   = '0;
                    if (w_in_act inside {bsal_pkg::ACT_INSERT, bsal_pkg::ACT_REMOVE,
                                         bsal_pkg::ACT_SEARCH, bsal_pkg::ACT_READ}) begin
                        // load match flags into the scan line
                        w_ctl.op    = bsal_pkg::CELL_LOAD;
                        w_ctl.value = w_in_value;
                        w_cell_pos  = IDX_W'(w_in_pos);
                        case (w_in_act)
                            bsal_pkg::ACT_INSERT: w_ctl.kind = bsal_pkg::CMP_GE;
                            bsal_pkg::ACT_READ:   w_ctl.kind = w_in_cap ? bsal_pkg::CMP_IDX
                                                                        : bsal_pkg::CMP_NONE;
                            default:              w_ctl.kind = bsal_pkg::CMP_EQ;
                        endcase
                        n_state = S_SCAN;
                    end else begin
                        n_state = S_APPLY;
                    end
                end
            end

            S_SCAN: begin
                if (w_hit) begin
                    n_found = 1'b1;
                    n_fpos  = IDX_W'({r_grp, w_hit_lane});
                    n_fval  = w_hit_val;
                    n_state = S_APPLY;
                end else if (r_grp == GRP_W'(NG - 1)) begin
                    n_found = 1'b0;
                    n_state = S_APPLY;
                end else begin
                    w_ctl.op = bsal_pkg::CELL_SHIFT;
                    n_grp    = r_grp + GRP_W'(1);
                end
            end

            S_APPLY: begin
                n_res_ok   = 1'b0;
                n_res_pos  = '0;
                n_res_item = r_value;
                case (r_act)
                    bsal_pkg::ACT_APPEND: begin
                        if (w_has_room) begin
                            w_ctl.op   = bsal_pkg::CELL_PUT;
                            w_cell_pos = IDX_W'(r_count);
                            n_res_ok   = 1'b1;
                            n_res_pos  = IDX_W'(r_count);
                            n_count    = r_count + CNT_W'(1);
                        end
                    end
                    bsal_pkg::ACT_INSERT: begin
                        if (w_has_room) begin
                            w_ctl.op   = bsal_pkg::CELL_INS;
                            w_cell_pos = r_found ? r_fpos : IDX_W'(r_count);
                            n_res_ok   = 1'b1;
                            n_res_pos  = r_found ? r_fpos : IDX_W'(r_count);
                            n_count    = r_count + CNT_W'(1);
                        end
                    end
                    bsal_pkg::ACT_REMOVE: begin
                        if (r_found) begin
                            w_ctl.op   = bsal_pkg::CELL_DEL;
                            w_cell_pos = r_fpos;
                            n_res_ok   = 1'b1;
                            n_res_pos  = r_fpos;
                            n_count    = r_count - CNT_W'(1);
                        end
                    end
                    bsal_pkg::ACT_SEARCH: begin
                        if (r_found) begin
                            n_res_ok  = 1'b1;
                            n_res_pos = r_fpos;
                        end
                    end
                    bsal_pkg::ACT_READ: begin
                        if (r_found) begin
                            n_res_ok   = 1'b1;
                            n_res_pos  = r_fpos;
                            n_res_item = r_fval;
                        end else begin
                            n_res_item = '0;
                        end
                    end
                    bsal_pkg::ACT_CLEAR: begin
                        n_res_ok = 1'b1;
                        n_count  = '0;
                    end
                    default: begin
                    end
                endcase
                n_res_len = n_count;
                n_state   = S_OUT;
            end

            S_OUT: begin
                // wait for a free output register
                if (!r_ovalid || i_m_tready) begin
                    n_ovalid   = 1'b1;
                    n_out_ok   = r_res_ok;
                    n_out_pos  = bsal_pkg::POS_W'(r_res_pos);
                    n_out_item = r_res_item;
                    n_out_len  = bsal_pkg::LEN_W'(r_res_len);
                    n_state    = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_grp    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_grp    <= n_grp;
            r_ovalid <= n_ovalid;
        end
        r_act      <= n_act;
        r_value    <= n_value;
        r_found    <= n_found;
        r_fpos     <= n_fpos;
        r_fval     <= n_fval;
        r_res_ok   <= n_res_ok;
        r_res_pos  <= n_res_pos;
        r_res_item <= n_res_item;
        r_res_len  <= n_res_len;
        r_out_ok   <= n_out_ok;
        r_out_pos  <= n_out_pos;
        r_out_item <= n_out_item;
        r_out_len  <= n_out_len;
    end

    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = {{PAD_W{1'b0}}, r_out_len, r_out_item, r_out_pos, r_out_ok};

    // checks
    `BSAL_ASSERT(a_count_cap, i_clk, i_rst_n, r_count <= CNT_W'(CAPACITY))
    `BSAL_ASSERT(a_accept_busy, i_clk, i_rst_n, w_accept |=> (r_state != S_IDLE))
    `BSAL_ASSERT(a_count_apply, i_clk, i_rst_n, (r_state != S_APPLY) |=> $stable(r_count))
    `BSAL_ASSERT_NEVER(a_grp_range, i_clk, i_rst_n, r_grp > GRP_W'(NG - 1))
    `BSAL_ASSERT(a_out_load, i_clk, i_rst_n, ((r_state == S_OUT) && !r_ovalid) |=> r_ovalid)

endmodule
